[src/rbb_pkg.sv]
// package: shared constants and the cordic arctangent table for rotated_box_bounds
package rbb_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int SCALE_BITS = 24;
    localparam int ID_BITS    = 16;
    localparam int ATAN_COUNT = 24;
    localparam int ZW         = 34;
    localparam int GAIN_BITS  = 24;
    localparam logic [GAIN_BITS-1:0] GAIN_Q24 = 24'd10188012;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic signed [ZW-1:0] atan_q32(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        unique case (i)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051E;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh00000A2FA;
            5'd15: v = 34'sh00000517D;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A30;
            5'd19: v = 34'sh000000518;
            5'd20: v = 34'sh00000028C;
            5'd21: v = 34'sh000000146;
            5'd22: v = 34'sh0000000A3;
            5'd23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/rbb_cordic_stage.sv]
// one registered cordic rotation stage acting on both half-diagonal corners
module rbb_cordic_stage #(
    parameter int DW    = 52,
    parameter int SHIFT = 0
) (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [DW-1:0]                 ax_in,
    input  logic signed [DW-1:0]                 ay_in,
    input  logic signed [DW-1:0]                 bx_in,
    input  logic signed [DW-1:0]                 by_in,
    input  logic signed [rbb_pkg::ZW-1:0]        z_in,
    output logic signed [DW-1:0]                 ax_out,
    output logic signed [DW-1:0]                 ay_out,
    output logic signed [DW-1:0]                 bx_out,
    output logic signed [DW-1:0]                 by_out,
    output logic signed [rbb_pkg::ZW-1:0]        z_out
);
    import rbb_pkg::*;

    logic signed [DW-1:0] ax_next, ay_next, bx_next, by_next;
    logic signed [ZW-1:0] z_next;
    logic signed [ZW-1:0] step_angle;

    assign step_angle = atan_q32(5'(SHIFT));

    // rotate toward zero residual angle, floor shifts
    always_comb begin
        if (z_in >= 0) begin
            ax_next = ax_in - (ay_in >>> SHIFT);
            ay_next = ay_in + (ax_in >>> SHIFT);
            bx_next = bx_in - (by_in >>> SHIFT);
            by_next = by_in + (bx_in >>> SHIFT);
            z_next  = z_in - step_angle;
        end else begin
            ax_next = ax_in + (ay_in >>> SHIFT);
            ay_next = ay_in - (ax_in >>> SHIFT);
            bx_next = bx_in + (by_in >>> SHIFT);
            by_next = by_in - (bx_in >>> SHIFT);
            z_next  = z_in + step_angle;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_out <= ax_next;
            ay_out <= ay_next;
            bx_out <= bx_next;
            by_out <= by_next;
            z_out  <= z_next;
        end
    end

endmodule

[src/rotated_box_bounds.sv]
// top level: scale, cordic-rotate and bound a 2d box per request
//
// Usage: one request per cycle on the s_ channel (s_valid/s_ready) carries a
// local box, a position, a Q8.16 scale, a binary angle and an instance id.
// One result per request leaves on the m_ channel (m_valid/m_ready) with the
// world-space axis-aligned bounds, saturated to the coordinate range, and the id.
// Depth: CORDIC_STAGES + 5 register stages.
// Throughput: one request per cycle unless stalled; the pipeline is one stage
// per cordic iteration plus prep, scale, magnitude-max, gain and output stages.
// Stall: all stages advance together on a global enable; while a result waits
// on m_valid with m_ready low, every stage holds and s_ready is low. Empty
// slots are not squeezed out during a stall.
// Reset: aresetn low (synchronous) clears every stage valid bit; no results
// are lost or repeated across stalls.
module rotated_box_bounds #(
    parameter int COORD_WIDTH   = rbb_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = rbb_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = rbb_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_box_low_x,
    input  logic signed [COORD_WIDTH-1:0] s_box_low_y,
    input  logic signed [COORD_WIDTH-1:0] s_box_high_x,
    input  logic signed [COORD_WIDTH-1:0] s_box_high_y,
    input  logic signed [COORD_WIDTH-1:0] s_place_x,
    input  logic signed [COORD_WIDTH-1:0] s_place_y,
    input  logic [rbb_pkg::SCALE_BITS-1:0] s_scale_factor,
    input  logic [ANGLE_WIDTH-1:0]        s_turn_angle,
    input  logic [rbb_pkg::ID_BITS-1:0]   s_instance_id,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_bound_low_x,
    output logic signed [COORD_WIDTH-1:0] m_bound_low_y,
    output logic signed [COORD_WIDTH-1:0] m_bound_high_x,
    output logic signed [COORD_WIDTH-1:0] m_bound_high_y,
    output logic [rbb_pkg::ID_BITS-1:0]   m_result_id
);
    import rbb_pkg::*;

    // widths: diff/sum need CW+1, product CW+1+24, after >>17 CW+8,
    // cordic grows up to ~1.65x and by two corners: DW = CW+11
    localparam int SW = COORD_WIDTH + 1;
    localparam int PW = SW + SCALE_BITS + 1;
    localparam int DW = COORD_WIDTH + 11;
    localparam int GW = DW + GAIN_BITS + 1;
    localparam int OW = COORD_WIDTH + 12;
    localparam int NS = CORDIC_STAGES + 5;
    localparam int PI = CORDIC_STAGES + 1;

    logic [NS-1:0] vld_reg;
    logic          en;

    // global advance: move unless the output holds an untaken result
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], s_valid};
        end
    end
    assign m_valid = vld_reg[NS-1];

    // stage 1: differences, sums and folded angle
    logic signed [SW-1:0]  dx_reg, dy_reg, sx_reg, sy_reg;
    logic [SCALE_BITS-1:0] sc1_reg;
    logic signed [ZW-1:0]  z1_reg;
    logic [ID_BITS-1:0]    id_pipe_reg [NS];
    logic signed [COORD_WIDTH-1:0] pxp_reg [PI+1];
    logic signed [COORD_WIDTH-1:0] pyp_reg [PI+1];

    // fold into [-quarter, +quarter): upper quarter of the half turn goes negative
    logic [ANGLE_WIDTH-2:0] am;
    logic signed [ANGLE_WIDTH-1:0] r_next;
    always_comb begin
        am = s_turn_angle[ANGLE_WIDTH-2:0];
        if (am[ANGLE_WIDTH-2]) begin
            r_next = $signed({1'b1, am});
        end else begin
            r_next = $signed({1'b0, am});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg  <= SW'(s_box_high_x) - SW'(s_box_low_x);
            dy_reg  <= SW'(s_box_high_y) - SW'(s_box_low_y);
            sx_reg  <= SW'(s_box_high_x) + SW'(s_box_low_x);
            sy_reg  <= SW'(s_box_high_y) + SW'(s_box_low_y);
            sc1_reg <= s_scale_factor;
            z1_reg  <= ZW'(r_next) <<< (32 - ANGLE_WIDTH);
        end
    end

    // id rides along every stage, the position as far as the world origin sum
    always_ff @(posedge aclk) begin
        if (en) begin
            id_pipe_reg[0] <= s_instance_id;
            pxp_reg[0]     <= s_place_x;
            pyp_reg[0]     <= s_place_y;
            for (int i = 1; i < NS; i++) id_pipe_reg[i] <= id_pipe_reg[i-1];
            for (int i = 1; i < PI + 1; i++) begin
                pxp_reg[i] <= pxp_reg[i-1];
                pyp_reg[i] <= pyp_reg[i-1];
            end
        end
    end

    // stage 2: scale with round half up: (v*s + 2^16) >>> 17
    logic signed [PW-1:0] sc_s;
    logic signed [PW-1:0] ex_p, ey_p, cx_p, cy_p;
    localparam logic signed [PW-1:0] HALF17 = PW'(65536);
    assign sc_s = $signed(PW'(sc1_reg));
    assign ex_p = PW'(dx_reg) * sc_s + HALF17;
    assign ey_p = PW'(dy_reg) * sc_s + HALF17;
    assign cx_p = PW'(sx_reg) * sc_s + HALF17;
    assign cy_p = PW'(sy_reg) * sc_s + HALF17;

    logic signed [DW-1:0] ex_reg, ey_reg;
    logic signed [OW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] z2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg <= DW'(ex_p >>> 17);
            ey_reg <= DW'(ey_p >>> 17);
            cx_reg <= OW'(cx_p >>> 17);
            cy_reg <= OW'(cy_p >>> 17);
            z2_reg <= z1_reg;
        end
    end

    // cordic chain, centre offsets delayed alongside
    logic signed [DW-1:0] ax_c [CORDIC_STAGES+1];
    logic signed [DW-1:0] ay_c [CORDIC_STAGES+1];
    logic signed [DW-1:0] bx_c [CORDIC_STAGES+1];
    logic signed [DW-1:0] by_c [CORDIC_STAGES+1];
    logic signed [ZW-1:0] z_c  [CORDIC_STAGES+1];
    logic signed [OW-1:0] cxd_reg [CORDIC_STAGES];
    logic signed [OW-1:0] cyd_reg [CORDIC_STAGES];

    assign ax_c[0] = ex_reg;
    assign ay_c[0] = ey_reg;
    assign bx_c[0] = ex_reg;
    assign by_c[0] = -ey_reg;
    assign z_c[0]  = z2_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        rbb_cordic_stage #(.DW(DW), .SHIFT(g)) u_stage (
            .aclk(aclk), .en(en),
            .ax_in(ax_c[g]), .ay_in(ay_c[g]), .bx_in(bx_c[g]), .by_in(by_c[g]),
            .z_in(z_c[g]),
            .ax_out(ax_c[g+1]), .ay_out(ay_c[g+1]), .bx_out(bx_c[g+1]),
            .by_out(by_c[g+1]), .z_out(z_c[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cxd_reg[0] <= cx_reg;
            cyd_reg[0] <= cy_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                cxd_reg[i] <= cxd_reg[i-1];
                cyd_reg[i] <= cyd_reg[i-1];
            end
        end
    end

    // magnitude max stage and world origin
    logic signed [DW-1:0] axm, aym, bxm, bym;
    assign axm = ax_c[CORDIC_STAGES] < 0 ? -ax_c[CORDIC_STAGES] : ax_c[CORDIC_STAGES];
    assign aym = ay_c[CORDIC_STAGES] < 0 ? -ay_c[CORDIC_STAGES] : ay_c[CORDIC_STAGES];
    assign bxm = bx_c[CORDIC_STAGES] < 0 ? -bx_c[CORDIC_STAGES] : bx_c[CORDIC_STAGES];
    assign bym = by_c[CORDIC_STAGES] < 0 ? -by_c[CORDIC_STAGES] : by_c[CORDIC_STAGES];

    logic signed [DW-1:0] mx_reg, my_reg;
    logic signed [OW-1:0] ox_reg, oy_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg <= axm > bxm ? axm : bxm;
            my_reg <= aym > bym ? aym : bym;
            ox_reg <= OW'(pxp_reg[PI]) + cxd_reg[CORDIC_STAGES-1];
            oy_reg <= OW'(pyp_reg[PI]) + cyd_reg[CORDIC_STAGES-1];
        end
    end

    // gain correction multiply, rounded half up
    localparam logic signed [GW-1:0] HALF24 = GW'(1) <<< 23;
    logic signed [DW-1:0] gx_reg, gy_reg;
    logic signed [OW-1:0] ox2_reg, oy2_reg;
    logic signed [GW-1:0] gxp, gyp;
    assign gxp = GW'(mx_reg) * $signed(GW'(GAIN_Q24)) + HALF24;
    assign gyp = GW'(my_reg) * $signed(GW'(GAIN_Q24)) + HALF24;
    always_ff @(posedge aclk) begin
        if (en) begin
            gx_reg  <= DW'(gxp >>> 24);
            gy_reg  <= DW'(gyp >>> 24);
            ox2_reg <= ox_reg;
            oy2_reg <= oy_reg;
        end
    end

    // bound sums, then saturation into the output register
    localparam logic signed [OW-1:0] TOP = OW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [OW-1:0] BOT = -TOP - OW'(1);
    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [OW-1:0] v);
        logic signed [COORD_WIDTH-1:0] r;
        if (v > TOP) r = TOP[COORD_WIDTH-1:0];
        else if (v < BOT) r = BOT[COORD_WIDTH-1:0];
        else r = v[COORD_WIDTH-1:0];
        return r;
    endfunction

    logic signed [OW-1:0] lx_w, ly_w, hx_w, hy_w;
    assign lx_w = ox2_reg - OW'(gx_reg);
    assign ly_w = oy2_reg - OW'(gy_reg);
    assign hx_w = ox2_reg + OW'(gx_reg);
    assign hy_w = oy2_reg + OW'(gy_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_bound_low_x  <= sat(lx_w);
            m_bound_low_y  <= sat(ly_w);
            m_bound_high_x <= sat(hx_w);
            m_bound_high_y <= sat(hy_w);
        end
    end
    assign m_result_id = id_pipe_reg[NS-1];

    // a stalled result holds its id and its low x bound
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_id) && $stable(m_bound_low_x))
        else $error("stalled result changed");
    // bounds are ordered for a nonnegative extent
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bound_low_x <= m_bound_high_x && m_bound_low_y <= m_bound_high_y)
        else $error("bounds out of order");
    // input accepted whenever the output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("pipeline blocked with empty output");

endmodule
